@@ src/lld_pkg.sv @@
// Shared widths and beat types for the line-to-line distance core.
// Used by lld_mul and line_line_distance_core; depends on nothing.
package lld_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int F_W       = PROD_W + 1;
  localparam int G_W       = DIFF_W + F_W + 3;
  localparam int FF_W      = 2 * F_W + 2;
  localparam int DIST_W    = 33;
  localparam int QUO_W     = 2 * DIST_W;
  localparam int MUL_DIGIT = 8;

  typedef struct packed {
    logic signed [COORD_W-1:0] line1_start_x;
    logic signed [COORD_W-1:0] line1_start_y;
    logic signed [COORD_W-1:0] line1_start_z;
    logic signed [COORD_W-1:0] line1_end_x;
    logic signed [COORD_W-1:0] line1_end_y;
    logic signed [COORD_W-1:0] line1_end_z;
    logic signed [COORD_W-1:0] line2_start_x;
    logic signed [COORD_W-1:0] line2_start_y;
    logic signed [COORD_W-1:0] line2_start_z;
    logic signed [COORD_W-1:0] line2_end_x;
    logic signed [COORD_W-1:0] line2_end_y;
    logic signed [COORD_W-1:0] line2_end_z;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              parallel_flag;
  } out_t;

endpackage

@@ src/lld_mul.sv @@
// Pipelined unsigned multiplier, several lanes, one digit of b per stage.
// Depends on lld_pkg for the digit width.
module lld_mul #(
  parameter int LANES = 1,
  parameter int WA    = 8,
  parameter int WB    = 8,
  parameter int TW    = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [LANES-1:0][WA-1:0]       a_i,
  input  logic [LANES-1:0][WB-1:0]       b_i,
  input  logic [TW-1:0]                  tag_i,
  output logic                           valid_o,
  output logic [LANES-1:0][WA+WB-1:0]    p_o,
  output logic [TW-1:0]                  tag_o
);

  localparam int K  = lld_pkg::MUL_DIGIT;
  localparam int N  = (WB + K - 1) / K;
  localparam int PW = WA + WB;
  localparam int BW = N * K;

  logic [N-1:0]                v_q;
  logic [LANES-1:0][PW-1:0]    acc_q [N];
  logic [LANES-1:0][WA-1:0]    a_q   [N];
  logic [LANES-1:0][BW-1:0]    b_q   [N];
  logic [TW-1:0]               tag_q [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic                        v_in;
    logic [LANES-1:0][PW-1:0]    acc_in, acc_d;
    logic [LANES-1:0][WA-1:0]    a_in;
    logic [LANES-1:0][BW-1:0]    b_in, b_d;
    logic [TW-1:0]               tag_in;

    if (j == 0) begin : g_first
      always_comb begin
        v_in   = valid_i;
        tag_in = tag_i;
        a_in   = a_i;
        acc_in = '0;
        for (int l = 0; l < LANES; l++) begin
          b_in[l] = BW'(b_i[l]);
        end
      end
    end else begin : g_next
      always_comb begin
        v_in   = v_q[j-1];
        tag_in = tag_q[j-1];
        a_in   = a_q[j-1];
        acc_in = acc_q[j-1];
        b_in   = b_q[j-1];
      end
    end

    always_comb begin
      logic [WA+K-1:0] pp;
      pp = '0;
      for (int l = 0; l < LANES; l++) begin
        pp       = a_in[l] * b_in[l][K-1:0];
        acc_d[l] = acc_in[l] + (PW'(pp) << (j * K));
        b_d[l]   = b_in[l] >> K;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j] <= acc_d;
        a_q[j]   <= a_in;
        b_q[j]   <= b_d;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign p_o     = acc_q[N-1];
  assign tag_o   = tag_q[N-1];

endmodule

@@ src/lld_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on nothing beyond its parameters.
module lld_div #(
  parameter int NW   = 16,
  parameter int DENW = 8,
  parameter int QW   = 8,
  parameter int TW   = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [QW-1:0]   q_o,
  output logic            ovf_o,
  output logic [TW-1:0]   tag_o
);

  localparam int CW = (NW - QW > DENW) ? NW - QW : DENW;

  logic [QW:0]        v_q;
  logic [DENW-1:0]    r_q   [QW+1];
  logic [QW-1:0]      l_q   [QW+1];
  logic [DENW-1:0]    den_q [QW+1];
  logic               ovf_q [QW+1];
  logic [TW-1:0]      tag_q [QW+1];

  // entry: high part against divisor decides overflow
  logic ovf_d;
  assign ovf_d = CW'(num_i >> QW) >= CW'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= ovf_d ? '0 : DENW'(num_i >> QW);
      l_q[0]   <= num_i[QW-1:0];
      den_q[0] <= den_i;
      ovf_q[0] <= ovf_d;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [DENW:0]   t;
    logic            ge;
    logic [DENW-1:0] r_d;

    always_comb begin
      t   = {r_q[j-1], l_q[j-1][QW-1]};
      ge  = t >= {1'b0, den_q[j-1]};
      r_d = ge ? DENW'(t - {1'b0, den_q[j-1]}) : t[DENW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= r_d;
        l_q[j]   <= {l_q[j-1][QW-2:0], ge};
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign q_o     = l_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign tag_o   = tag_q[QW];

endmodule

@@ src/lld_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on nothing beyond its parameters.
module lld_sqrt #(
  parameter int QW = 8,
  parameter int TW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [QW-1:0]      x_i,
  input  logic [TW-1:0]      tag_i,
  output logic               valid_o,
  output logic [QW/2-1:0]    root_o,
  output logic [TW-1:0]      tag_o
);

  localparam int RTW = QW / 2;
  localparam int RMW = RTW + 2;

  logic [RTW-1:0]     v_q;
  logic [RMW-1:0]     rem_q  [RTW];
  logic [RTW-1:0]     root_q [RTW];
  logic [QW-1:0]      x_q    [RTW];
  logic [TW-1:0]      tag_q  [RTW];

  for (genvar j = 0; j < RTW; j++) begin : g_stage
    logic            v_in;
    logic [RMW-1:0]  rem_in, rem_d;
    logic [RTW-1:0]  root_in;
    logic [QW-1:0]   x_in;
    logic [TW-1:0]   tag_in;
    logic [RMW+1:0]  s, t;
    logic            ge;

    if (j == 0) begin : g_first
      always_comb begin
        v_in    = valid_i;
        rem_in  = '0;
        root_in = '0;
        x_in    = x_i;
        tag_in  = tag_i;
      end
    end else begin : g_next
      always_comb begin
        v_in    = v_q[j-1];
        rem_in  = rem_q[j-1];
        root_in = root_q[j-1];
        x_in    = x_q[j-1];
        tag_in  = tag_q[j-1];
      end
    end

    always_comb begin
      s     = {rem_in, x_in[QW-1:QW-2]};
      t     = (RMW+2)'({root_in, 2'b01});
      ge    = s >= t;
      rem_d = ge ? RMW'(s - t) : RMW'(s);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= {root_in[RTW-2:0], ge};
        x_q[j]    <= x_in << 2;
        tag_q[j]  <= tag_in;
      end
    end
  end

  assign valid_o = v_q[RTW-1];
  assign root_o  = root_q[RTW-1];
  assign tag_o   = tag_q[RTW-1];

endmodule

@@ src/line_line_distance_core.sv @@
// Line-to-line distance core: |c.(a x b)| / |a x b| over a fixed-depth pipeline.
// Stages: 6 arithmetic stages, 9 + 13 multiplier digit stages,
// 67 divider stages, 33 square-root stages and the output register.
// Throughput one beat per cycle; an output stall while a beat is valid freezes the whole pipeline.
// Reset clears every valid bit at once; no clearing pass.
// Depends on lld_pkg, lld_mul, lld_div and lld_sqrt.
module line_line_distance_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lld_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lld_pkg::out_t out_o
);

  localparam int CW   = lld_pkg::COORD_W;
  localparam int DW   = lld_pkg::DIFF_W;
  localparam int PW   = lld_pkg::PROD_W;
  localparam int FW   = lld_pkg::F_W;
  localparam int GW   = lld_pkg::G_W;
  localparam int FFW  = lld_pkg::FF_W;
  localparam int QW   = lld_pkg::QUO_W;
  localparam int DSTW = lld_pkg::DIST_W;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: direction and offset vectors
  logic signed [CW-1:0] pt [12];
  logic signed [DW-1:0] a_d [3], b_d [3], c_d [3];
  logic signed [DW-1:0] a_q [3], b_q [3], c_q [3];
  logic                 s1_v_q;

  always_comb begin
    pt[0]  = in_i.line1_start_x;
    pt[1]  = in_i.line1_start_y;
    pt[2]  = in_i.line1_start_z;
    pt[3]  = in_i.line1_end_x;
    pt[4]  = in_i.line1_end_y;
    pt[5]  = in_i.line1_end_z;
    pt[6]  = in_i.line2_start_x;
    pt[7]  = in_i.line2_start_y;
    pt[8]  = in_i.line2_start_z;
    pt[9]  = in_i.line2_end_x;
    pt[10] = in_i.line2_end_y;
    pt[11] = in_i.line2_end_z;
    for (int k = 0; k < 3; k++) begin
      a_d[k] = DW'(pt[3+k]) - DW'(pt[k]);
      b_d[k] = DW'(pt[9+k]) - DW'(pt[6+k]);
      c_d[k] = DW'(pt[6+k]) - DW'(pt[k]);
    end
  end

  // stage 2: cross-product partial terms
  logic signed [PW-1:0] t1_d [3], t2_d [3], t1_q [3], t2_q [3];
  logic signed [DW-1:0] c2_q [3];
  logic                 s2_v_q;

  always_comb begin
    t1_d[0] = a_q[1] * b_q[2];
    t2_d[0] = a_q[2] * b_q[1];
    t1_d[1] = a_q[2] * b_q[0];
    t2_d[1] = a_q[0] * b_q[2];
    t1_d[2] = a_q[0] * b_q[1];
    t2_d[2] = a_q[1] * b_q[0];
  end

  // stage 3: f = a x b
  logic signed [FW-1:0] f_d [3], f_q [3];
  logic signed [DW-1:0] c3_q [3];
  logic                 s3_v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_d[k] = FW'(t1_q[k]) - FW'(t2_q[k]);
    end
  end

  // stage 4: magnitudes and signs
  logic [FW-1:0] fm_d [3], fm_q [3];
  logic [DW-1:0] cm_d [3], cm_q [3];
  logic [2:0]    sg_d, sg_q;
  logic          s4_v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fm_d[k] = f_q[k][FW-1] ? FW'(-f_q[k]) : FW'(f_q[k]);
      cm_d[k] = c3_q[k][DW-1] ? DW'(-c3_q[k]) : DW'(c3_q[k]);
      sg_d[k] = f_q[k][FW-1] ^ c3_q[k][DW-1];
    end
  end

  // products c.f and |f|^2, three lanes each
  logic [5:0][FW-1:0]   m1_a, m1_b;
  logic [5:0][2*FW-1:0] m1_p;
  logic [2:0]           m1_sg;
  logic                 m1_v;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m1_a[k]   = fm_q[k];
      m1_b[k]   = FW'(cm_q[k]);
      m1_a[3+k] = fm_q[k];
      m1_b[3+k] = fm_q[k];
    end
  end

  lld_mul #(
    .LANES(6),
    .WA   (FW),
    .WB   (FW),
    .TW   (3)
  ) u_mul_f (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s4_v_q),
    .a_i    (m1_a),
    .b_i    (m1_b),
    .tag_i  (sg_q),
    .valid_o(m1_v),
    .p_o    (m1_p),
    .tag_o  (m1_sg)
  );

  // stage 5: g = c.f and |f|^2 sums
  logic signed [GW-1:0] g_d, g_q;
  logic [FFW-1:0]       ff_d, ff_q;
  logic                 s5_v_q;

  always_comb begin
    logic signed [GW-1:0] term [3];
    for (int k = 0; k < 3; k++) begin
      term[k] = m1_sg[k] ? -$signed(m1_p[k][GW-1:0]) : $signed(m1_p[k][GW-1:0]);
    end
    g_d  = term[0] + term[1] + term[2];
    ff_d = FFW'(m1_p[3]) + FFW'(m1_p[4]) + FFW'(m1_p[5]);
  end

  // stage 6: |g| and parallel detect
  logic [GW-1:0]  gm_q;
  logic [FFW-1:0] ff6_q;
  logic           z6_q;
  logic           s6_v_q;

  // g^2
  logic [0:0][GW-1:0]   m2_a;
  logic [0:0][2*GW-1:0] m2_p;
  logic [FFW:0]         m2_tag;
  logic                 m2_v;

  assign m2_a = gm_q;

  lld_mul #(
    .LANES(1),
    .WA   (GW),
    .WB   (GW),
    .TW   (FFW + 1)
  ) u_mul_g (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s6_v_q),
    .a_i    (m2_a),
    .b_i    (m2_a),
    .tag_i  ({z6_q, ff6_q}),
    .valid_o(m2_v),
    .p_o    (m2_p),
    .tag_o  (m2_tag)
  );

  // floor(g^2 / |f|^2)
  logic [QW-1:0] dq;
  logic          dv, dovf, dz;

  lld_div #(
    .NW  (2 * GW),
    .DENW(FFW),
    .QW  (QW),
    .TW  (1)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(m2_v),
    .num_i  (m2_p[0]),
    .den_i  (m2_tag[FFW-1:0]),
    .tag_i  (m2_tag[FFW]),
    .valid_o(dv),
    .q_o    (dq),
    .ovf_o  (dovf),
    .tag_o  (dz)
  );

  logic [DSTW-1:0] sq_root;
  logic [1:0]      sq_tag;
  logic            sq_v;

  lld_sqrt #(
    .QW(QW),
    .TW(2)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(dv),
    .x_i    (dq),
    .tag_i  ({dz, dovf}),
    .valid_o(sq_v),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  lld_pkg::out_t out_d, out_q;
  logic          out_v_q;

  always_comb begin
    out_d.parallel_flag = sq_tag[1];
    if (sq_tag[1]) begin
      out_d.distance = '0;
    end else if (sq_tag[0]) begin
      out_d.distance = '1;
    end else begin
      out_d.distance = sq_root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= m1_v;
      s6_v_q  <= s5_v_q;
      out_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= b_d;
      c_q   <= c_d;
      t1_q  <= t1_d;
      t2_q  <= t2_d;
      c2_q  <= c_q;
      f_q   <= f_d;
      c3_q  <= c2_q;
      fm_q  <= fm_d;
      cm_q  <= cm_d;
      sg_q  <= sg_d;
      g_q   <= g_d;
      ff_q  <= ff_d;
      gm_q  <= g_q[GW-1] ? GW'(-g_q) : GW'(g_q);
      ff6_q <= ff_q;
      z6_q  <= ff_q == '0;
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.parallel_flag |-> out_o.distance == '0)
    else $error("parallel beat with non-zero distance");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_v_q) && $stable(s6_v_q))
    else $error("pipeline moved while stalled");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && sq_v && sq_tag[0] && !sq_tag[1] |=> out_o.distance == '1)
    else $error("overflowed quotient not saturated");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for line_line_distance_core: directed table then random line pairs.
// Expected beats come from the table or an exact wide-integer predictor; depends on lld_pkg and the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE      = 32'h0001_0000;
  localparam int MAX_C    = 32'h7fff_ffff;
  localparam int MIN_C    = 32'h8000_0000;
  localparam int DRAIN    = 160;
  localparam int HOLD_LEN = 400;

  typedef struct {
    lld_pkg::in_t  pts;
    bit            typed;
    lld_pkg::out_t res;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  lld_pkg::in_t  in_i;
  lld_pkg::out_t out_o;

  lld_pkg::out_t dist_q[$];
  bit            cur_typed;
  lld_pkg::out_t cur_res;
  bit            hold_req;
  int            n_err;
  bit            burst;
  row_t          rows[$];

  line_line_distance_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i, .out_valid_o, .out_stall_i, .out_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic lld_pkg::out_t calc_distance(lld_pkg::in_t p);
    logic signed [255:0] s1[3], e1[3], s2[3], e2[3];
    logic signed [255:0] a[3], b[3], c[3], f[3], g, ff;
    logic [255:0] g2, uff, dd, lhs;
    logic [32:0] dval, d;
    int u, v;
    lld_pkg::out_t r;
    s1[0] = p.line1_start_x; s1[1] = p.line1_start_y; s1[2] = p.line1_start_z;
    e1[0] = p.line1_end_x;   e1[1] = p.line1_end_y;   e1[2] = p.line1_end_z;
    s2[0] = p.line2_start_x; s2[1] = p.line2_start_y; s2[2] = p.line2_start_z;
    e2[0] = p.line2_end_x;   e2[1] = p.line2_end_y;   e2[2] = p.line2_end_z;
    for (int k = 0; k < 3; k++) begin
      a[k] = e1[k] - s1[k];
      b[k] = e2[k] - s2[k];
      c[k] = s2[k] - s1[k];
    end
    g  = '0;
    ff = '0;
    for (int k = 0; k < 3; k++) begin
      u = (k + 1) % 3;
      v = (k + 2) % 3;
      f[k] = a[u] * b[v] - a[v] * b[u];
    end
    for (int k = 0; k < 3; k++) begin
      g  = g + c[k] * f[k];
      ff = ff + f[k] * f[k];
    end
    r = '0;
    if (ff == 0) begin
      r.parallel_flag = 1'b1;
      return r;
    end
    g2   = g * g;
    uff  = ff;
    dval = '0;
    for (int bt = lld_pkg::DIST_W - 1; bt >= 0; bt--) begin
      d   = dval | (33'd1 << bt);
      dd  = d;
      lhs = dd * dd * uff;
      if (lhs <= g2) dval = d;
    end
    r.distance = dval;
    return r;
  endfunction

  function automatic int small_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic lld_pkg::in_t random_pair();
    lld_pkg::in_t p;
    int sel, k, ax, ay, az;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (sel < 7) begin
      p = {small_coord(4 * ONE), small_coord(4 * ONE), small_coord(4 * ONE),
           small_coord(4 * ONE), small_coord(4 * ONE), small_coord(4 * ONE),
           small_coord(4 * ONE), small_coord(4 * ONE), small_coord(4 * ONE),
           small_coord(4 * ONE), small_coord(4 * ONE), small_coord(4 * ONE)};
    end else if (sel < 9) begin
      // parallel: second direction a whole multiple of the first
      ax = small_coord(4096);
      ay = small_coord(4096);
      az = small_coord(4096);
      k  = small_coord(8);
      p = {small_coord(ONE), small_coord(ONE), small_coord(ONE), 32'd0, 32'd0, 32'd0,
           small_coord(ONE), small_coord(ONE), small_coord(ONE), 32'd0, 32'd0, 32'd0};
      p.line1_end_x = p.line1_start_x + ax;
      p.line1_end_y = p.line1_start_y + ay;
      p.line1_end_z = p.line1_start_z + az;
      p.line2_end_x = p.line2_start_x + k * ax;
      p.line2_end_y = p.line2_start_y + k * ay;
      p.line2_end_z = p.line2_start_z + k * az;
    end else begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p.line2_end_x = p.line2_start_x;
      p.line2_end_y = p.line2_start_y;
      p.line2_end_z = p.line2_start_z;
    end
    return p;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_pair(lld_pkg::in_t p, bit typed, lld_pkg::out_t res);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= p;
    cur_typed  <= typed;
    cur_res    <= res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic add_row(lld_pkg::in_t p, bit typed, lld_pkg::out_t res);
    row_t r;
    r.pts   = p;
    r.typed = typed;
    r.res   = res;
    rows.push_back(r);
  endtask

  // input side: record expectation for every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      dist_q.push_back(cur_typed ? cur_res : calc_distance(in_i));
  end

  // output side
  always @(posedge clk_i) begin
    lld_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dist_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected beat: distance=%0d parallel=%0b",
                                  out_o.distance, out_o.parallel_flag);
      end else begin
        want = dist_q.pop_front();
        if (out_o.distance !== want.distance || out_o.parallel_flag !== want.parallel_flag) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: want distance=%0d parallel=%0b, got distance=%0d parallel=%0b",
                     want.distance, want.parallel_flag, out_o.distance, out_o.parallel_flag);
        end
      end
    end
  end

  // receiver
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = draw_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    lld_pkg::out_t par, unit, none;
    int            waited;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;
    cur_typed  = 1'b0;
    cur_res    = '0;
    hold_req   = 1'b0;
    n_err      = 0;
    burst      = 1'b0;
    par  = '{distance: '0, parallel_flag: 1'b1};
    unit = '{distance: 33'(ONE), parallel_flag: 1'b0};
    none = '0;

    add_row('0, 1'b1, par);
    add_row({12{MAX_C}}, 1'b1, par);
    add_row({12{MIN_C}}, 1'b1, par);
    add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0,
             32'd0, 32'd0, ONE, 32'd0, ONE, ONE}, 1'b1, unit);
    add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0,
             32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0}, 1'b1, none);
    add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0,
             32'd0, ONE, 32'd0, 2 * ONE, ONE, 32'd0}, 1'b1, par);
    add_row({ONE, ONE, ONE, ONE, ONE, ONE,
             32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0}, 1'b1, par);
    add_row({MIN_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C,
             MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MAX_C}, 1'b0, none);
    add_row({MIN_C, 32'd0, MAX_C, MAX_C, 32'd0, MAX_C,
             MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C}, 1'b0, none);
    add_row({MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MIN_C,
             MIN_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C}, 1'b0, none);
    add_row({32'd1, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0,
             32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1}, 1'b0, none);
    add_row({-ONE, 3 * ONE, 32'sd5, ONE / 2, -7 * ONE, 32'sd12345,
             -32'd99, ONE, -ONE, 8 * ONE, -32'sd3, 2 * ONE}, 1'b0, none);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pair(rows[i].pts, rows[i].typed, rows[i].res);

    for (int i = 0; i < 1200; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i == 300) hold_req = 1'b1;
      if (i == 700) begin
        in_valid_i <= 1'b0;
        wait (dist_q.size() == 0);
        @(posedge clk_i);
      end
      send_pair(random_pair(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (dist_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN) @(posedge clk_i);
    if (n_err == 0 && dist_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/lld_pkg.sv
src/lld_mul.sv
src/lld_div.sv
src/lld_sqrt.sv
src/line_line_distance_core.sv
bench/tb.sv
